FILE: design/hsvpick_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsvpick_pkg
// Shared widths, codes, structs and reciprocal constants of the HSV picker.
// ----------------------------------------------------------------------------
package hsvpick_pkg;

    localparam int HUE_W   = 12;
    localparam int SAT_W   = 10;
    localparam int VAL_W   = 10;
    localparam int CH_W    = 8;
    localparam int LEVEL_W = 15;
    localparam int STEP_W  = 16;
    localparam int PCT_W   = 7;
    localparam int CFG_W   = 15;
    localparam int SWEEP_W = 13;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    // shared multiplier geometry
    localparam int MUL_A_W = 15;
    localparam int MUL_B_W = 20;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // divide by constant: floor(x * MUL >> SHIFT)
    localparam int SC_SHIFT     = 19;
    localparam int DIV60_SHIFT  = 18;
    localparam int DIV100_SHIFT = 22;
    localparam int DIV25_SHIFT  = 18;
    localparam logic [MUL_B_W-1:0] DIV60_MUL  = 20'd4370;
    localparam logic [MUL_B_W-1:0] DIV100_MUL = 20'd41944;
    localparam logic [MUL_B_W-1:0] DIV25_MUL  = 20'd10486;

    typedef enum logic [1:0] {
        OP_IND     = 2'd0,
        OP_COLOUR  = 2'd1,
        OP_RESTORE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        MODE_STAY = 2'd0,
        MODE_HUE  = 2'd1,
        MODE_SAT  = 2'd2,
        MODE_VAL  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_TOP      = 2'd0,
        CFG_HUE_STEP = 2'd1,
        CFG_SAT_STEP = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [VAL_W-1:0] val;
    } hsv_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

endpackage
`default_nettype wire

FILE: design/hsv_picker_led_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_picker_led_controller
// HSV colour picker with mode indicator, driving RGB and indicator duty values.
// ----------------------------------------------------------------------------
// Each accepted transaction yields exactly one result transaction. Indicator
// ticks, colour ticks without the button held and unused op codes go from
// acceptance straight to the emit state. Colour ticks with the button held
// and restores first run the HSV to RGB conversion: eleven passes through one
// shared multiplier under the conversion sequencer, then the emit state. In
// the emit state the result is loaded into the output register once that is
// free, and m_tvalid rises with it. s_tready is low from acceptance until the
// result is loaded into the output register; a result still waiting there
// does not block the next transaction until its own result is ready.
module hsv_picker_led_controller
    import hsvpick_pkg::*;
#(
    parameter int HSV_SCALE = 10
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [39:0]  s_tdata,  // double_click, held, hue_in, sat_in, val_in, zero pad
    input  wire logic [1:0]   s_tuser,  // op
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [79:0]       m_tdata,  // red, green, blue, indicator_level, mode_now,
                                        // save_pulse, hue_out, sat_out, val_out, zero pad
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    localparam int RECIP_SC_INT = ((1 << SC_SHIFT) + HSV_SCALE - 1) / HSV_SCALE;
    localparam logic [MUL_B_W-1:0] RECIP_SC = MUL_B_W'(RECIP_SC_INT);
    localparam logic [SWEEP_W-1:0] HUE_BOUND =
        SWEEP_W'((360 * HSV_SCALE > 4095) ? 4095 : 360 * HSV_SCALE);
    localparam logic [SWEEP_W-1:0] PCT_BOUND =
        SWEEP_W'((100 * HSV_SCALE > 1023) ? 1023 : 100 * HSV_SCALE);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    state_t               state_reg;
    logic                 start_reg;
    logic [CFG_W-1:0]     top_reg;
    logic [CFG_W-1:0]     hue_step_reg;
    logic [CFG_W-1:0]     sat_step_reg;
    mode_t                mode_reg;
    logic [LEVEL_W-1:0]   level_reg;
    logic signed [STEP_W-1:0] step_reg;
    logic                 down_reg;
    logic [HUE_W-1:0]     hue_reg;
    logic [SAT_W-1:0]     sat_reg;
    logic [VAL_W-1:0]     val_reg;
    logic                 save_reg;

    logic                 m_tvalid_reg;
    rgb_t                 out_rgb_reg;
    logic [LEVEL_W-1:0]   out_level_reg;
    mode_t                out_mode_reg;
    logic                 out_save_reg;
    logic [HUE_W-1:0]     out_hue_reg;
    logic [SAT_W-1:0]     out_sat_reg;
    logic [VAL_W-1:0]     out_val_reg;

    mode_t                mode_next;
    logic [LEVEL_W-1:0]   level_next;
    logic signed [STEP_W-1:0] step_next;
    logic                 down_next;
    logic [HUE_W-1:0]     hue_next;
    logic [SAT_W-1:0]     sat_next;
    logic [VAL_W-1:0]     val_next;
    logic                 save_next;
    logic                 need_conv;

    mode_t                mode_tmp;
    logic [LEVEL_W-1:0]   lvl_tmp;
    logic signed [STEP_W-1:0] step_tmp;
    logic signed [STEP_W-1:0] step_mag;
    logic signed [16:0]   blink_sum;
    logic signed [16:0]   top_s;
    logic [SWEEP_W-1:0]   comp_cur;
    logic [SWEEP_W-1:0]   comp_bound;
    logic [SWEEP_W-1:0]   comp_step;
    logic [SWEEP_W-1:0]   comp_new;
    logic                 sweep_dir;

    logic                 in_fire;
    logic                 out_free;
    logic                 conv_done;
    rgb_t                 conv_rgb;
    hsv_t                 conv_hsv;

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign conv_hsv = '{hue: hue_reg, sat: sat_reg, val: val_reg};

    hsvpick_conv #(
        .RECIP_SC (RECIP_SC)
    ) u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .hsv     (conv_hsv),
        .done    (conv_done),
        .rgb     (conv_rgb)
    );

    // indicator tick
    always_comb begin
        mode_tmp = mode_reg;
        lvl_tmp  = level_reg;
        step_tmp = step_reg;
        if (s_tdata[0]) begin
            mode_tmp = mode_t'(2'(mode_reg + 2'd1));
            lvl_tmp  = (mode_tmp == MODE_VAL) ? top_reg : '0;
            priority if (mode_tmp == MODE_HUE) begin
                step_tmp = STEP_W'(hue_step_reg);
            end else if (mode_tmp == MODE_SAT) begin
                step_tmp = STEP_W'(sat_step_reg);
            end else begin
                step_tmp = '0;
            end
        end
        step_mag  = step_tmp[STEP_W-1] ? -step_tmp : step_tmp;
        blink_sum = 17'(lvl_tmp) + {step_tmp[STEP_W-1], step_tmp};
        top_s     = 17'(top_reg);
    end

    // colour sweep
    always_comb begin
        priority if (mode_reg == MODE_HUE) begin
            comp_cur   = SWEEP_W'(hue_reg);
            comp_bound = HUE_BOUND;
        end else if (mode_reg == MODE_SAT) begin
            comp_cur   = SWEEP_W'(sat_reg);
            comp_bound = PCT_BOUND;
        end else begin
            comp_cur   = SWEEP_W'(val_reg);
            comp_bound = PCT_BOUND;
        end
        sweep_dir = down_reg;
        if (comp_cur == '0) begin
            sweep_dir = 1'b0;
        end
        if (comp_cur >= comp_bound) begin
            sweep_dir = 1'b1;
        end
        if (sweep_dir) begin
            comp_step = (comp_cur == '0) ? '0 : comp_cur - 1'b1;
        end else begin
            comp_step = comp_cur + 1'b1;
        end
        comp_new = (comp_step > comp_bound) ? comp_bound : comp_step;
    end

    always_comb begin
        mode_next  = mode_reg;
        level_next = level_reg;
        step_next  = step_reg;
        down_next  = down_reg;
        hue_next   = hue_reg;
        sat_next   = sat_reg;
        val_next   = val_reg;
        save_next  = 1'b0;
        need_conv  = 1'b0;
        unique case (s_tuser)
            OP_IND: begin
                mode_next = mode_tmp;
                save_next = s_tdata[0] && (mode_tmp == MODE_STAY);
                if (s_tdata[0]) begin
                    down_next = 1'b0;
                end
                priority if (mode_tmp == MODE_VAL) begin
                    level_next = top_reg;
                    step_next  = step_tmp;
                end else if (blink_sum >= top_s) begin
                    level_next = top_reg;
                    step_next  = -step_mag;
                end else if (blink_sum[16] || blink_sum == '0) begin
                    level_next = '0;
                    step_next  = step_mag;
                end else begin
                    level_next = blink_sum[LEVEL_W-1:0];
                    step_next  = step_tmp;
                end
            end
            OP_COLOUR: begin
                if (s_tdata[1]) begin
                    need_conv = 1'b1;
                    if (mode_reg != MODE_STAY) begin
                        down_next = sweep_dir;
                    end
                    unique case (mode_reg)
                        MODE_HUE: hue_next = comp_new[HUE_W-1:0];
                        MODE_SAT: sat_next = comp_new[SAT_W-1:0];
                        MODE_VAL: val_next = comp_new[VAL_W-1:0];
                        default:  hue_next = hue_reg;
                    endcase
                end
            end
            OP_RESTORE: begin
                hue_next  = s_tdata[13:2];
                sat_next  = s_tdata[23:14];
                val_next  = s_tdata[33:24];
                need_conv = 1'b1;
            end
            default: need_conv = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            top_reg      <= 15'd1000;
            hue_step_reg <= 15'd50;
            sat_step_reg <= 15'd500;
            mode_reg     <= MODE_STAY;
            level_reg    <= '0;
            step_reg     <= '0;
            down_reg     <= 1'b0;
            hue_reg      <= '0;
            sat_reg      <= '0;
            val_reg      <= '0;
            save_reg     <= 1'b0;
        end else begin
            start_reg <= in_fire && need_conv;
            if ((state_reg == ST_EMIT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_TOP:      top_reg      <= cfg_wdata;
                    CFG_HUE_STEP: hue_step_reg <= cfg_wdata;
                    CFG_SAT_STEP: sat_step_reg <= cfg_wdata;
                    default:      top_reg      <= top_reg;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        mode_reg  <= mode_next;
                        level_reg <= level_next;
                        step_reg  <= step_next;
                        down_reg  <= down_next;
                        hue_reg   <= hue_next;
                        sat_reg   <= sat_next;
                        val_reg   <= val_next;
                        save_reg  <= save_next;
                        state_reg <= need_conv ? ST_CONV : ST_EMIT;
                    end
                end
                ST_CONV: begin
                    if (conv_done) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        out_rgb_reg   <= conv_rgb;
                        out_level_reg <= level_reg;
                        out_mode_reg  <= mode_reg;
                        out_save_reg  <= save_reg;
                        out_hue_reg   <= hue_reg;
                        out_sat_reg   <= sat_reg;
                        out_val_reg   <= val_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b000000, out_val_reg, out_sat_reg, out_hue_reg, out_save_reg,
                       out_mode_reg, out_level_reg, out_rgb_reg.blue, out_rgb_reg.green,
                       out_rgb_reg.red};

`ifndef SYNTHESIS
    conv_done_in_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        conv_done |-> state_reg == ST_CONV)
        else $error("conversion finished outside conversion wait");

    busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready)
        else $error("ready high right after an accepted transaction");

    save_only_in_stay: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && out_save_reg) |-> out_mode_reg == MODE_STAY)
        else $error("save pulse outside stay mode");

    start_only_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |-> state_reg == ST_CONV)
        else $error("conversion started while not waiting for it");
`endif

endmodule
`default_nettype wire

FILE: design/hsvpick_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsvpick_mul
// Shared multiplier with a registered product, one result per cycle.
// ----------------------------------------------------------------------------
module hsvpick_mul
    import hsvpick_pkg::*;
(
    input  wire logic              aclk,
    input  wire mul_req_t          req,
    output logic [PROD_W-1:0]      prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(req.a) * PROD_W'(req.b);
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

FILE: design/hsvpick_conv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsvpick_conv
// Six-sector HSV to RGB conversion sequenced over the shared multiplier.
// ----------------------------------------------------------------------------
module hsvpick_conv
    import hsvpick_pkg::*;
#(
    parameter logic [MUL_B_W-1:0] RECIP_SC = 20'd52429
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic start,
    input  wire hsv_t hsv,
    output logic      done,
    output rgb_t      rgb
);

    typedef enum logic [3:0] {
        C_IDLE, C_H, C_S, C_V, C_Q, C_VM, C_VMD, C_FULL,
        C_LOW, C_DF, C_RISE, C_FALL, C_OUT
    } cstate_t;

    cstate_t           state_reg;
    logic              done_reg;
    rgb_t              rgb_reg;
    logic [HUE_W-1:0]  h_reg;
    logic [PCT_W-1:0]  s_reg;
    logic [PCT_W-1:0]  v_reg;
    logic [PCT_W-1:0]  vm_reg;
    logic [5:0]        f_reg;
    logic [2:0]        sector_reg;
    logic [CH_W-1:0]   full_reg;
    logic [CH_W-1:0]   low_reg;
    logic [CH_W-1:0]   rise_reg;
    logic [12:0]       df_reg;

    mul_req_t          mul_req;
    logic [PROD_W-1:0] mul_prod;

    logic [SAT_W-1:0]  pct_raw;
    logic [PCT_W-1:0]  pct_cap;
    logic [6:0]        q_w;
    logic [12:0]       q6_prod;
    logic [2:0]        sector_w;
    logic [5:0]        f_w;
    logic [CH_W-1:0]   fall_w;
    logic [12:0]       rise_num;
    logic [12:0]       fall_num;
    logic [16:0]       rise_x17;
    logic [16:0]       fall_x17;
    logic [MUL_A_W-1:0] v255;
    logic [MUL_A_W-1:0] vm255;

    hsvpick_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (mul_prod)
    );

    always_comb begin
        pct_raw  = mul_prod[SC_SHIFT +: SAT_W];
        pct_cap  = (pct_raw > SAT_W'(PCT_MAX)) ? PCT_MAX : pct_raw[PCT_W-1:0];
        q_w      = mul_prod[DIV60_SHIFT +: 7];
        q6_prod  = 13'(q_w) * 13'd43;
        sector_w = 3'(q_w - 7'(q6_prod[12:8]) * 7'd6);
        f_w      = 6'(h_reg - 12'(q_w) * 12'd60);
        fall_w   = mul_prod[DIV25_SHIFT +: CH_W];
        rise_num = 13'(vm_reg) * 13'd60 + mul_prod[12:0];
        fall_num = 13'(v_reg) * 13'd60 - df_reg;
        rise_x17 = {rise_num, 4'b0000} + 17'(rise_num);
        fall_x17 = {fall_num, 4'b0000} + 17'(fall_num);
        v255     = {v_reg, 8'h00} - MUL_A_W'(v_reg);
        vm255    = {vm_reg, 8'h00} - MUL_A_W'(vm_reg);
    end

    always_comb begin
        mul_req = '0;
        unique case (state_reg)
            C_H: begin
                mul_req.a = MUL_A_W'(hsv.hue);
                mul_req.b = RECIP_SC;
            end
            C_S: begin
                mul_req.a = MUL_A_W'(hsv.sat);
                mul_req.b = RECIP_SC;
            end
            C_V: begin
                mul_req.a = MUL_A_W'(hsv.val);
                mul_req.b = RECIP_SC;
            end
            C_Q: begin
                mul_req.a = MUL_A_W'(h_reg);
                mul_req.b = DIV60_MUL;
            end
            C_VM: begin
                mul_req.a = MUL_A_W'(PCT_MAX - s_reg);
                mul_req.b = MUL_B_W'(v_reg);
            end
            C_VMD: begin
                mul_req.a = mul_prod[MUL_A_W-1:0];
                mul_req.b = DIV100_MUL;
            end
            C_FULL: begin
                mul_req.a = v255;
                mul_req.b = DIV100_MUL;
            end
            C_LOW: begin
                mul_req.a = vm255;
                mul_req.b = DIV100_MUL;
            end
            C_DF: begin
                mul_req.a = MUL_A_W'(v_reg - vm_reg);
                mul_req.b = MUL_B_W'(f_reg);
            end
            C_RISE: begin
                mul_req.a = MUL_A_W'(rise_x17[16:4]);
                mul_req.b = DIV25_MUL;
            end
            C_FALL: begin
                mul_req.a = MUL_A_W'(fall_x17[16:4]);
                mul_req.b = DIV25_MUL;
            end
            default: mul_req = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            rgb_reg   <= '0;
        end else begin
            done_reg <= (state_reg == C_OUT);
            unique case (state_reg)
                C_IDLE: begin
                    if (start) begin
                        state_reg <= C_H;
                    end
                end
                C_H: state_reg <= C_S;
                C_S: begin
                    h_reg     <= mul_prod[SC_SHIFT +: HUE_W];
                    state_reg <= C_V;
                end
                C_V: begin
                    s_reg     <= pct_cap;
                    state_reg <= C_Q;
                end
                C_Q: begin
                    v_reg     <= pct_cap;
                    state_reg <= C_VM;
                end
                C_VM: begin
                    f_reg      <= f_w;
                    sector_reg <= sector_w;
                    state_reg  <= C_VMD;
                end
                C_VMD: state_reg <= C_FULL;
                C_FULL: begin
                    vm_reg    <= mul_prod[DIV100_SHIFT +: PCT_W];
                    state_reg <= C_LOW;
                end
                C_LOW: begin
                    full_reg  <= mul_prod[DIV100_SHIFT +: CH_W];
                    state_reg <= C_DF;
                end
                C_DF: begin
                    low_reg   <= mul_prod[DIV100_SHIFT +: CH_W];
                    state_reg <= C_RISE;
                end
                C_RISE: begin
                    df_reg    <= mul_prod[12:0];
                    state_reg <= C_FALL;
                end
                C_FALL: begin
                    rise_reg  <= mul_prod[DIV25_SHIFT +: CH_W];
                    state_reg <= C_OUT;
                end
                C_OUT: begin
                    unique case (sector_reg)
                        3'd0: rgb_reg <= '{red: full_reg, green: rise_reg, blue: low_reg};
                        3'd1: rgb_reg <= '{red: fall_w, green: full_reg, blue: low_reg};
                        3'd2: rgb_reg <= '{red: low_reg, green: full_reg, blue: rise_reg};
                        3'd3: rgb_reg <= '{red: low_reg, green: fall_w, blue: full_reg};
                        3'd4: rgb_reg <= '{red: rise_reg, green: low_reg, blue: full_reg};
                        default: rgb_reg <= '{red: full_reg, green: low_reg, blue: fall_w};
                    endcase
                    state_reg <= C_IDLE;
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign rgb  = rgb_reg;

endmodule
`default_nettype wire
